@@ hw/rtl/kmd_pkg.sv @@
package kmd_pkg;

    // Key index as it leaves the front: row (3 bits) times column count (4 bits)
    // plus column fits in 8 bits.
    localparam int KEY_FIELD_W = 8;

    // APB register map
    localparam int APB_AW = 4;
    localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [1:0] REG_THRESHOLD    = 2'd2;

    localparam logic [3:0] ROW_COUNT_RST    = 4'd8;
    localparam logic [3:0] COLUMN_COUNT_RST = 4'd8;
    localparam logic [7:0] THRESHOLD_RST    = 8'd3;

    localparam logic REQ_SAMPLE      = 1'b0;
    localparam logic REQ_TABLE_WRITE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  sample_row;
        logic [2:0]  sample_column;
        logic        sample_level;
        logic [5:0]  table_index;
        logic [15:0] table_code;
    } t_item;

    typedef struct packed {
        logic [15:0] event_code;
        logic        event_press;
        logic [2:0]  event_row;
        logic [2:0]  event_column;
    } t_event;

    // Classified work handed from front to back
    typedef struct packed {
        logic                   is_table;
        logic [KEY_FIELD_W-1:0] key;
        logic [2:0]             row;
        logic [2:0]             column;
        logic                   level;
        logic [15:0]            code;
    } t_task;

    typedef struct packed {
        logic [3:0] row_count;
        logic [3:0] column_count;
        logic [7:0] threshold;
    } t_cfg;

endpackage

@@ hw/rtl/kmd_ram.sv @@
module kmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/kmd_fifo.sv @@
module kmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/kmd_front.sv @@
module kmd_front #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8,
    parameter int KEY_SLOTS   = 64
) (
    input  logic           i_accept,
    input  kmd_pkg::t_item i_item,
    input  kmd_pkg::t_cfg  i_cfg,
    output logic           o_push,
    output kmd_pkg::t_task o_task
);
    import kmd_pkg::*;

    logic                   row_ok, col_ok, key_ok, table_ok, sample_ok;
    logic [KEY_FIELD_W-1:0] key_sum;

    assign row_ok = ({1'b0, i_item.sample_row} < i_cfg.row_count) &&
                    ({2'b00, i_item.sample_row} < 5'(MAX_ROWS));
    assign col_ok = ({1'b0, i_item.sample_column} < i_cfg.column_count) &&
                    ({2'b00, i_item.sample_column} < 5'(MAX_COLUMNS));

    assign key_sum = KEY_FIELD_W'(i_item.sample_row) * KEY_FIELD_W'(i_cfg.column_count)
                   + KEY_FIELD_W'(i_item.sample_column);

    assign key_ok    = {1'b0, key_sum} < 9'(KEY_SLOTS);
    assign table_ok  = {3'b000, i_item.table_index} < 9'(KEY_SLOTS);
    assign sample_ok = row_ok && col_ok && key_ok;

    // Drop out-of-range samples and table writes here; dropped work never reaches the back.
    assign o_push = i_accept &&
                    ((i_item.req_type == REQ_TABLE_WRITE) ? table_ok : sample_ok);

    always_comb begin
        o_task.is_table = (i_item.req_type == REQ_TABLE_WRITE);
        o_task.key      = o_task.is_table ? KEY_FIELD_W'(i_item.table_index) : key_sum;
        o_task.row      = i_item.sample_row;
        o_task.column   = i_item.sample_column;
        o_task.level    = i_item.sample_level;
        o_task.code     = i_item.table_code;
    end

endmodule

@@ hw/rtl/kmd_back.sv @@
module kmd_back #(
    parameter int KEY_SLOTS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_vld,
    input  kmd_pkg::t_task  i_head,
    output logic            o_pop,
    input  logic [7:0]      i_threshold,
    input  logic            i_out_full,
    output logic            o_ev_push,
    output kmd_pkg::t_event o_ev
);
    import kmd_pkg::*;

    localparam int KEY_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    logic             head_sample, head_table, load, s1_free, s1_retire;
    logic [KEY_W-1:0] head_key;

    logic             r_s1_vld;
    logic [KEY_W-1:0] r_s1_key;
    logic [2:0]       r_s1_row, r_s1_col;
    logic             r_s1_level;
    logic             r_s1_init;
    logic             r_byp;
    logic             r_byp_level;
    logic [7:0]       r_byp_cnt;
    logic [KEY_SLOTS-1:0] r_valid;

    logic [8:0]  state_rd;
    logic [15:0] code_rd;
    logic        cur_level, same, fire, wr_level;
    logic [7:0]  cur_cnt, cnt_inc, wr_cnt;

    assign head_key    = i_head.key[KEY_W-1:0];
    assign head_sample = i_head_vld && !i_head.is_table;
    assign head_table  = i_head_vld && i_head.is_table;
    assign s1_free     = !r_s1_vld || s1_retire;
    assign load        = head_sample && s1_free;
    assign o_pop       = head_table || load;

    kmd_ram #(.WIDTH(9), .DEPTH(KEY_SLOTS), .AW(KEY_W)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (s1_retire),
        .i_waddr (r_s1_key),
        .i_wdata ({wr_level, wr_cnt}),
        .i_re    (load),
        .i_raddr (head_key),
        .o_rdata (state_rd)
    );

    kmd_ram #(.WIDTH(16), .DEPTH(KEY_SLOTS), .AW(KEY_W)) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (head_table),
        .i_waddr (head_key),
        .i_wdata (i_head.code),
        .i_re    (load),
        .i_raddr (head_key),
        .o_rdata (code_rd)
    );

    // Never-written key reads as released with a clear counter.
    always_comb begin
        if (r_byp) begin
            cur_level = r_byp_level;
            cur_cnt   = r_byp_cnt;
        end else if (r_s1_init) begin
            cur_level = state_rd[8];
            cur_cnt   = state_rd[7:0];
        end else begin
            cur_level = 1'b0;
            cur_cnt   = '0;
        end
        same     = (r_s1_level == cur_level);
        cnt_inc  = (cur_cnt < i_threshold) ? cur_cnt + 8'd1 : cur_cnt;
        fire     = !same && !(cnt_inc < i_threshold);
        wr_level = fire ? r_s1_level : cur_level;
        wr_cnt   = (same || fire) ? 8'd0 : cnt_inc;
    end

    assign s1_retire = r_s1_vld && (!fire || !i_out_full);
    assign o_ev_push = r_s1_vld && fire && !i_out_full;

    always_comb begin
        o_ev.event_code   = code_rd;
        o_ev.event_press  = r_s1_level;
        o_ev.event_row    = r_s1_row;
        o_ev.event_column = r_s1_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_byp    <= 1'b0;
            r_valid  <= '0;
        end else begin
            if (s1_retire) begin
                r_valid[r_s1_key] <= 1'b1;
            end
            if (load) begin
                r_s1_vld <= 1'b1;
                r_byp    <= s1_retire && (r_s1_key == head_key);
            end else if (s1_retire) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1_key    <= head_key;
            r_s1_row    <= i_head.row;
            r_s1_col    <= i_head.column;
            r_s1_level  <= i_head.level;
            r_s1_init   <= r_valid[head_key];
            r_byp_level <= wr_level;
            r_byp_cnt   <= wr_cnt;
        end
    end

    a_load_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_head.is_table) |-> s1_free)
        else $error("sample taken while the update stage is held");

    a_event_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev_push |-> (r_s1_vld && !i_out_full))
        else $error("event pushed without a live sample or room");

    a_bypass_on_same_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && s1_retire && (r_s1_key == head_key)) |=> r_byp)
        else $error("back-to-back update of one key missed the bypass");

endmodule

@@ hw/rtl/key_matrix_debouncer.sv @@
// Channel   | Handshake                         | Payload
// ----------+-----------------------------------+----------------------------------
// input     | push / full, beat: push & !full   | i_item  (sample or table write)
// result    | pop / empty, beat: pop & !empty   | o_event (key press or release)
// config    | APB psel/penable/pwrite, pready=1 | paddr 4*index, pwdata, prdata
//
// One item per cycle sustained unless a full result queue stalls an event; sample events go
// via task queue and update stage to the result queue. The rate is set by the per-key
// state RAM read-modify-write, with a bypass for same-key samples in consecutive cycles.
// Reset clears per-key valid flops at once: no clearing pass, ready the cycle after reset.
// A pending event with the result queue full holds the update stage; the two-entry task
// queue then fills and raises full.
module key_matrix_debouncer #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input queue side
    input  logic                       push,
    output logic                       full,
    input  kmd_pkg::t_item             i_item,
    // result queue side
    output logic                       empty,
    input  logic                       pop,
    output kmd_pkg::t_event            o_event,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kmd_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import kmd_pkg::*;

    localparam int KEY_SLOTS = MAX_ROWS * MAX_COLUMNS;

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    logic   in_beat;
    logic   task_push, task_full, task_empty, task_pop;
    t_task  task_in, task_head;
    logic   ev_push, ev_full;
    t_event ev;

    // Config registers: write on the APB access phase.
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_count    <= ROW_COUNT_RST;
            r_cfg.column_count <= COLUMN_COUNT_RST;
            r_cfg.threshold    <= THRESHOLD_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ROW_COUNT:    r_cfg.row_count    <= pwdata[3:0];
                REG_COLUMN_COUNT: r_cfg.column_count <= pwdata[3:0];
                REG_THRESHOLD:    r_cfg.threshold    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ROW_COUNT:    prdata = {28'd0, r_cfg.row_count};
            REG_COLUMN_COUNT: prdata = {28'd0, r_cfg.column_count};
            REG_THRESHOLD:    prdata = {24'd0, r_cfg.threshold};
            default:          prdata = '0;
        endcase
    end

    // Front: classify the beat, drop out-of-range work.
    assign full    = task_full;
    assign in_beat = push && !task_full;

    kmd_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .KEY_SLOTS   (KEY_SLOTS)
    ) u_front (
        .i_accept (in_beat),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .o_push   (task_push),
        .o_task   (task_in)
    );

    // Task queue decouples front from the update stage.
    kmd_fifo #(.WIDTH($bits(t_task)), .DEPTH(2)) u_task_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (task_push),
        .i_data  (task_in),
        .o_full  (task_full),
        .i_pop   (task_pop),
        .o_data  (task_head),
        .o_empty (task_empty)
    );

    // Back: per-key debounce update and keycode lookup.
    kmd_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_vld  (!task_empty),
        .i_head      (task_head),
        .o_pop       (task_pop),
        .i_threshold (r_cfg.threshold),
        .i_out_full  (ev_full),
        .o_ev_push   (ev_push),
        .o_ev        (ev)
    );

    // Result queue: hold events until the consumer pops them.
    kmd_fifo #(.WIDTH($bits(t_event)), .DEPTH(2)) u_event_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ev_push),
        .i_data  (ev),
        .o_full  (ev_full),
        .i_pop   (pop),
        .o_data  (o_event),
        .o_empty (empty)
    );

endmodule
